// ===== rtl/led_strip_pattern_generator_assert.svh =====
// Assertion macros used by the LED strip pattern generator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef LED_STRIP_PATTERN_GENERATOR_ASSERT_SVH
`define LED_STRIP_PATTERN_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lspg_pkg.sv =====
// Package for the LED strip pattern generator: payload types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lspg_pkg;

    localparam int COLOR_W       = 24;
    localparam int LEVEL_W       = 8;
    localparam int FUNC_W        = 3;
    localparam int POS_W         = 7;
    localparam int LED_COUNT_DEF = 32;
    localparam int TAIL_LEN      = 5;

    // Pattern codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_IDLE    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_STATIC  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BREATHE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RAINBOW = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_METEOR  = 3'd4;

    // Colour wheel phases.
    localparam logic [2:0] WHEEL_G_UP = 3'd0;
    localparam logic [2:0] WHEEL_R_DN = 3'd1;
    localparam logic [2:0] WHEEL_B_UP = 3'd2;
    localparam logic [2:0] WHEEL_G_DN = 3'd3;
    localparam logic [2:0] WHEEL_R_UP = 3'd4;
    localparam logic [2:0] WHEEL_B_DN = 3'd5;

    // Breathe phases.
    localparam logic [1:0] FADE_INIT = 2'd0;
    localparam logic [1:0] FADE_DOWN = 2'd1;
    localparam logic [1:0] FADE_UP   = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 8'd0;
    localparam logic [LEVEL_W-1:0] RED_RESET  = 8'd25;

    // Meteor tail masks, brightest first after the head pixel.
    localparam logic [COLOR_W-1:0] MASK_T1 = 24'b001111110011111100111111;
    localparam logic [COLOR_W-1:0] MASK_T2 = 24'b000011110000111100001111;
    localparam logic [COLOR_W-1:0] MASK_T3 = 24'b000000110000001100000011;
    localparam logic [COLOR_W-1:0] MASK_T4 = 24'b000000010000000100000001;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COLOR_W-1:0] color;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_grb;
        logic               last_pixel;
    } pix_t;

    // Frame descriptor handed from the effect engine to the pixel sequencer.
    typedef struct packed {
        logic               launch;
        logic               meteor;
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   head;
    } frame_t;

endpackage

`default_nettype wire

// ===== rtl/lspg_effect.sv =====
// Effect engine: holds the rainbow, breathe and meteor state and builds a frame descriptor.
// Depends on lspg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lspg_effect #(
    parameter int LED_COUNT = lspg_pkg::LED_COUNT_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  lspg_pkg::item_t      item,
    output lspg_pkg::frame_t     frame
);
    import lspg_pkg::*;

    localparam logic [POS_W-1:0] WRAP = POS_W'(LED_COUNT + TAIL_LEN);

    logic [LEVEL_W-1:0] green_reg, green_next;
    logic [LEVEL_W-1:0] red_reg, red_next;
    logic [LEVEL_W-1:0] blue_reg, blue_next;
    logic [2:0]         wheel_reg, wheel_next;
    logic [1:0]         fade_reg, fade_next;
    logic [COLOR_W-1:0] target_reg, target_next;
    logic [POS_W-1:0]   tail_reg, tail_next;

    logic [LEVEL_W-1:0] tg, tr, tb;
    logic [LEVEL_W-1:0] fg, fr, fb;
    logic [1:0]         fph;
    logic [COLOR_W-1:0] ftgt;
    logic [POS_W-1:0]   head;

    assign tg = target_reg[23:16];
    assign tr = target_reg[15:8];
    assign tb = target_reg[7:0];
    assign head = (tail_reg > WRAP) ? WRAP : tail_reg;

    // Breathe step, before the colour-change check.
    always_comb
    begin
        fg   = green_reg;
        fr   = red_reg;
        fb   = blue_reg;
        fph  = fade_reg;
        ftgt = target_reg;
        case (fade_reg)
            FADE_DOWN:
            begin
                if (green_reg == LEVEL_ZERO && red_reg == LEVEL_ZERO && blue_reg == LEVEL_ZERO)
                begin
                    fph = FADE_UP;
                end
                else
                begin
                    if (green_reg != LEVEL_ZERO) fg = green_reg - 8'd1;
                    if (red_reg != LEVEL_ZERO)   fr = red_reg - 8'd1;
                    if (blue_reg != LEVEL_ZERO)  fb = blue_reg - 8'd1;
                end
            end
            FADE_UP:
            begin
                if (green_reg == tg && red_reg == tr && blue_reg == tb)
                begin
                    fph = FADE_DOWN;
                end
                else
                begin
                    if (green_reg != tg) fg = green_reg + 8'd1;
                    if (red_reg != tr)   fr = red_reg + 8'd1;
                    if (blue_reg != tb)  fb = blue_reg + 8'd1;
                end
            end
            default:
            begin
                ftgt = item.color;
                fg   = item.color[23:16];
                fr   = item.color[15:8];
                fb   = item.color[7:0];
                fph  = FADE_DOWN;
            end
        endcase
        if (item.color != ftgt)
        begin
            fph = FADE_INIT;
        end
    end

    always_comb
    begin
        green_next  = green_reg;
        red_next    = red_reg;
        blue_next   = blue_reg;
        wheel_next  = wheel_reg;
        fade_next   = fade_reg;
        target_next = target_reg;
        tail_next   = tail_reg;
        frame.launch = 1'b0;
        frame.meteor = 1'b0;
        frame.color  = item.color;
        frame.head   = head;
        if (accept)
        begin
            case (item.func)
                FUNC_STATIC:
                begin
                    frame.launch = 1'b1;
                end
                FUNC_BREATHE:
                begin
                    frame.launch = 1'b1;
                    green_next   = fg;
                    red_next     = fr;
                    blue_next    = fb;
                    fade_next    = fph;
                    target_next  = ftgt;
                    frame.color  = {fg, fr, fb};
                end
                FUNC_RAINBOW:
                begin
                    frame.launch = 1'b1;
                    frame.color  = {green_reg, red_reg, blue_reg};
                    case (wheel_reg)
                        WHEEL_G_UP:
                            if (green_reg == LEVEL_MAX) wheel_next = WHEEL_R_DN;
                            else green_next = green_reg + 8'd1;
                        WHEEL_R_DN:
                            if (red_reg == LEVEL_ZERO) wheel_next = WHEEL_B_UP;
                            else red_next = red_reg - 8'd1;
                        WHEEL_B_UP:
                            if (blue_reg == LEVEL_MAX) wheel_next = WHEEL_G_DN;
                            else blue_next = blue_reg + 8'd1;
                        WHEEL_G_DN:
                            if (green_reg == LEVEL_ZERO) wheel_next = WHEEL_R_UP;
                            else green_next = green_reg - 8'd1;
                        WHEEL_R_UP:
                            if (red_reg == LEVEL_MAX) wheel_next = WHEEL_B_DN;
                            else red_next = red_reg + 8'd1;
                        WHEEL_B_DN:
                            if (blue_reg == LEVEL_ZERO) wheel_next = WHEEL_G_UP;
                            else blue_next = blue_reg - 8'd1;
                        default:
                            wheel_next = WHEEL_G_UP;
                    endcase
                end
                FUNC_METEOR:
                begin
                    frame.launch = 1'b1;
                    frame.meteor = 1'b1;
                    tail_next    = (head >= WRAP) ? '0 : head + 7'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg  <= LEVEL_ZERO;
            red_reg    <= RED_RESET;
            blue_reg   <= LEVEL_ZERO;
            wheel_reg  <= WHEEL_G_UP;
            fade_reg   <= FADE_INIT;
            target_reg <= '0;
            tail_reg   <= '0;
        end
        else
        begin
            green_reg  <= green_next;
            red_reg    <= red_next;
            blue_reg   <= blue_next;
            wheel_reg  <= wheel_next;
            fade_reg   <= fade_next;
            target_reg <= target_next;
            tail_reg   <= tail_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lspg_pixel.sv =====
// Pixel sequencer: holds one frame descriptor and sends its pixels through an output register.
// Depends on lspg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "led_strip_pattern_generator_assert.svh"

module lspg_pixel #(
    parameter int LED_COUNT = lspg_pkg::LED_COUNT_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  lspg_pkg::frame_t     frame,
    output logic                 busy_stall,
    output logic                 pix_valid,
    input  wire                  pix_stall,
    output lspg_pkg::pix_t       pix
);
    import lspg_pkg::*;

    localparam int CNT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int IDX_W = $clog2(2 * LED_COUNT + TAIL_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LED_COUNT - 1);
    localparam logic [IDX_W-1:0] IDX_HEAD = IDX_W'(LED_COUNT);
    localparam logic [IDX_W-1:0] IDX_WRAP = IDX_W'(LED_COUNT + TAIL_LEN);

    logic               busy_reg;
    logic               meteor_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [POS_W-1:0]   head_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               pix_valid_reg;
    pix_t               pix_reg, pix_next;

    logic               adv;
    logic               cnt_last;
    logic [IDX_W-1:0]   idx;
    logic [2:0]         tail_off;

    assign adv        = busy_reg && (!pix_valid_reg || !pix_stall);
    assign cnt_last   = (cnt_reg == CNT_LAST);
    assign busy_stall = busy_reg && !(adv && cnt_last);
    assign idx        = IDX_W'(head_reg) + IDX_W'(cnt_reg);
    assign tail_off   = 3'(idx - IDX_HEAD);

    always_comb
    begin
        pix_next.last_pixel = cnt_last;
        pix_next.pixel_grb  = color_reg;
        if (meteor_reg)
        begin
            if (idx >= IDX_HEAD && idx < IDX_WRAP)
            begin
                case (tail_off)
                    3'd0:    pix_next.pixel_grb = color_reg;
                    3'd1:    pix_next.pixel_grb = color_reg & MASK_T1;
                    3'd2:    pix_next.pixel_grb = color_reg & MASK_T2;
                    3'd3:    pix_next.pixel_grb = color_reg & MASK_T3;
                    default: pix_next.pixel_grb = color_reg & MASK_T4;
                endcase
            end
            else
            begin
                pix_next.pixel_grb = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (!pix_stall)
            begin
                pix_valid_reg <= 1'b0;
            end

            if (frame.launch)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (adv)
            begin
                if (cnt_last)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.launch)
        begin
            meteor_reg <= frame.meteor;
            color_reg  <= frame.color;
            head_reg   <= frame.head;
        end
        if (adv)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    `LSPG_ASSERT_IMP(a_launch_free, frame.launch, !busy_reg || (adv && cnt_last), "frame launched over a busy frame")
    `LSPG_ASSERT_NXT(a_last_marked, adv && cnt_last, pix_valid_reg && pix_reg.last_pixel, "last pixel not marked")
    `LSPG_ASSERT_NXT(a_mid_unmarked, adv && !cnt_last, pix_valid_reg && !pix_reg.last_pixel, "early last pixel")
    `LSPG_ASSERT_IMP(a_head_range, busy_reg && meteor_reg, IDX_W'(head_reg) <= IDX_WRAP, "meteor head beyond wrap")

endmodule

`default_nettype wire

// ===== rtl/led_strip_pattern_generator.sv =====
// Top level of the LED strip pattern generator: effect engine plus pixel sequencer.
// Depends on lspg_pkg, lspg_effect and lspg_pixel.
`timescale 1ns / 1ps
`default_nettype none

// Usage.
// The item channel (item_valid, item_stall, item) carries one frame tick: a pattern
// code and a GRB colour. A transfer happens at a rising edge with item_valid high
// and item_stall low. Idle and unused codes produce no pixels and change nothing.
// Every other code produces one frame of LED_COUNT pixels on the pix channel
// (pix_valid, pix_stall, pix), one transfer per pixel, the final one flagged by
// last_pixel.
// The first pixel of a frame enters the output register after its tick has been
// latched into the sequencer's frame registers. Throughput: one pixel per cycle
// while pix_stall is low. A new tick is taken in the same cycle as the previous
// frame's last pixel enters the output register, so frames follow each other
// without a gap.
// When the receiver holds pix_stall, the pixel in the output register stays put,
// the pixel counter pauses and item_stall stays high until the frame completes.
// Reset clears the wheel to its starting colour (dim red), the breathe phase,
// its target and the meteor position, and drops any frame in progress.

module led_strip_pattern_generator #(
    parameter int LED_COUNT = lspg_pkg::LED_COUNT_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  lspg_pkg::item_t      item,
    output logic                 pix_valid,
    input  wire                  pix_stall,
    output lspg_pkg::pix_t       pix
);
    import lspg_pkg::*;

    logic   accept;
    frame_t frame;

    // A tick is transferred whenever the sequencer can take a new frame.
    assign accept = item_valid && !item_stall;

    lspg_effect #(
        .LED_COUNT (LED_COUNT)
    ) u_effect (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .frame  (frame)
    );

    lspg_pixel #(
        .LED_COUNT (LED_COUNT)
    ) u_pixel (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .busy_stall (item_stall),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix)
    );

endmodule

`default_nettype wire
